[sv/irq_dbg_pkg.sv]
// ---------------------------------------------------------------------------
// Interrupt and debug entry arbiter package
// Request and result types, event and action codes, register map and the
// interrupt line priority function.
// ---------------------------------------------------------------------------
package irq_dbg_pkg;

    typedef enum logic [1:0] {
        MODE_BOUNDARY  = 2'd0,
        MODE_HALT_WIRE = 2'd1,
        MODE_DRET      = 2'd2,
        MODE_WAKE_WIRE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DEBUG = 2'd1,
        ACT_IRQ   = 2'd2
    } action_t;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_TRIGGER = 3'd2;
    localparam logic [2:0] CAUSE_HALTREQ = 3'd3;
    localparam logic [2:0] CAUSE_STEP    = 3'd4;

    localparam int          CFG_ADDR_WIDTH   = 5;
    localparam logic [2:0]  REG_VECTOR_BASE  = 3'd0;
    localparam logic [2:0]  REG_VECTORED     = 3'd1;
    localparam logic [2:0]  REG_TRIG_ENABLE  = 3'd2;
    localparam logic [2:0]  REG_TRIG_ADDRESS = 3'd3;
    localparam logic [2:0]  REG_DEBUG_HANDLER = 3'd4;
    localparam logic [2:0]  REG_WIRED_MASK   = 3'd5;

    localparam logic [31:0] VECTOR_BASE_MASK  = 32'hFFFF_FF00;
    localparam logic [31:0] WIRED_MASK_RESET  = 32'hFFFF_0888;
    localparam logic [4:0]  DEFAULT_LINE      = 5'd7;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] pc;
        logic [31:0] pending_lines;
        logic        global_irq_enable;
        logic        suppress_async;
        logic        wire_level;
        logic        step_enable;
        logic        step_irq_enable;
    } evt_t;

    typedef struct packed {
        action_t     action;
        logic [2:0]  debug_cause;
        logic [4:0]  interrupt_id;
        logic [31:0] saved_pc;
        logic [31:0] target_pc;
        logic        wfi_release;
    } res_t;

    // Fast lines 31..16 win, then 11, then 3; any other line reports as 7.
    function automatic logic [4:0] pick_line(input logic [31:0] p);
        logic [4:0] id;
        id = DEFAULT_LINE;
        if (p[3])
        begin
            id = 5'd3;
        end
        if (p[11])
        begin
            id = 5'd11;
        end
        for (int n = 16; n < 32; n++)
        begin
            if (p[n])
            begin
                id = 5'(n);
            end
        end
        return id;
    endfunction

endpackage

[sv/irq_dbg_stream_if.sv]
// ---------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one request or result item per accepted handshake.
// ---------------------------------------------------------------------------
interface irq_dbg_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/riscv_irq_debug_entry_arbiter_top.sv]
// ---------------------------------------------------------------------------
// Interrupt and debug entry arbiter
// Decides per instruction boundary between debug entry, interrupt take or
// nothing, and tracks halt request, single step and debug mode state.
// ---------------------------------------------------------------------------
// Usage:
//   evt carries one request per boundary check, halt wire change, dret or
//   wake wire change. Every accepted request yields exactly one result on
//   res: action, debug cause, interrupt id, saved and target pc, and the
//   WFI release flag.
//   The decision is made in the cycle the request is accepted and lands in
//   a result register, so the result is visible in the next cycle. One
//   request is taken every cycle unless the receiver stalls; the state it
//   updates is ready for the request in the very next cycle.
//   evt.ready stays high while the result register is empty or its result
//   is taken in the same cycle. When the receiver stalls, the held result
//   waits and evt.ready drops until it is taken.
//   The APB port writes the six configuration registers at byte addresses
//   0, 4, .. 20 and reads them back; write only while no request is in
//   flight.
//   Reset (rst_n low) restores the configuration defaults, clears the halt,
//   step and debug mode state and empties the result register.
// ---------------------------------------------------------------------------
module riscv_irq_debug_entry_arbiter_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    irq_dbg_stream_if.sink                         evt,
    irq_dbg_stream_if.source                       res,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [irq_dbg_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    // Configuration registers
    logic [31:0] vector_base_reg;
    logic        vectored_reg;
    logic        trig_enable_reg;
    logic [31:0] trig_address_reg;
    logic [31:0] debug_handler_reg;
    logic [31:0] wired_mask_reg;

    // Arbiter state
    logic        halt_level_reg,    halt_level_next;
    logic        debug_request_reg, debug_request_next;
    logic [2:0]  request_cause_reg, request_cause_next;
    logic        step_armed_reg,    step_armed_next;
    logic [31:0] step_address_reg,  step_address_next;
    logic        in_debug_reg,      in_debug_next;

    // Result register
    logic               res_valid_reg;
    irq_dbg_pkg::res_t  res_data_reg, res_data_next;

    logic        accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic        trig;
    logic        step_miss;
    logic [31:0] lines;
    logic [4:0]  line_id;
    logic [31:0] vec_base;
    logic [31:0] vec_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    assign evt.ready = !res_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    always_comb
    begin
        case (cfg_index)
            irq_dbg_pkg::REG_VECTOR_BASE:   prdata = vector_base_reg;
            irq_dbg_pkg::REG_VECTORED:      prdata = {31'd0, vectored_reg};
            irq_dbg_pkg::REG_TRIG_ENABLE:   prdata = {31'd0, trig_enable_reg};
            irq_dbg_pkg::REG_TRIG_ADDRESS:  prdata = trig_address_reg;
            irq_dbg_pkg::REG_DEBUG_HANDLER: prdata = debug_handler_reg;
            irq_dbg_pkg::REG_WIRED_MASK:    prdata = wired_mask_reg;
            default:                        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_base_reg   <= 32'd0;
            vectored_reg      <= 1'b0;
            trig_enable_reg   <= 1'b0;
            trig_address_reg  <= 32'd0;
            debug_handler_reg <= 32'd0;
            wired_mask_reg    <= irq_dbg_pkg::WIRED_MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                irq_dbg_pkg::REG_VECTOR_BASE:   vector_base_reg   <= pwdata;
                irq_dbg_pkg::REG_VECTORED:      vectored_reg      <= pwdata[0];
                irq_dbg_pkg::REG_TRIG_ENABLE:   trig_enable_reg   <= pwdata[0];
                irq_dbg_pkg::REG_TRIG_ADDRESS:  trig_address_reg  <= pwdata;
                irq_dbg_pkg::REG_DEBUG_HANDLER: debug_handler_reg <= pwdata;
                irq_dbg_pkg::REG_WIRED_MASK:    wired_mask_reg    <= pwdata;
                default:                        ;
            endcase
        end
    end

    // While a step window is open, the trigger only fires at the step address.
    assign step_miss = step_armed_reg && (evt.data.pc != step_address_reg);
    assign trig = trig_enable_reg && !in_debug_reg &&
                  (!debug_request_reg || request_cause_reg == irq_dbg_pkg::CAUSE_HALTREQ) &&
                  !step_miss && (evt.data.pc == trig_address_reg);

    assign lines     = evt.data.pending_lines & wired_mask_reg;
    assign line_id   = irq_dbg_pkg::pick_line(lines);
    assign vec_base  = vector_base_reg & irq_dbg_pkg::VECTOR_BASE_MASK;
    assign vec_entry = vectored_reg ? (vec_base + {25'd0, line_id, 2'b00}) : vec_base;

    always_comb
    begin
        logic       dreq;
        logic [2:0] cause;

        halt_level_next    = halt_level_reg;
        debug_request_next = debug_request_reg;
        request_cause_next = request_cause_reg;
        step_armed_next    = step_armed_reg;
        step_address_next  = step_address_reg;
        in_debug_next      = in_debug_reg;
        dreq               = debug_request_reg;
        cause              = request_cause_reg;

        res_data_next              = '0;
        res_data_next.action       = irq_dbg_pkg::ACT_NONE;
        res_data_next.debug_cause  = irq_dbg_pkg::CAUSE_NONE;

        case (evt.data.mode)
            irq_dbg_pkg::MODE_BOUNDARY:
            begin
                // A suppressed boundary only lets the trigger through.
                if (!evt.data.suppress_async || trig)
                begin
                    dreq  = debug_request_reg || trig || (halt_level_reg && !in_debug_reg);
                    cause = trig ? irq_dbg_pkg::CAUSE_TRIGGER : request_cause_reg;
                    if (step_miss && !in_debug_reg && !dreq)
                    begin
                        dreq  = 1'b1;
                        cause = irq_dbg_pkg::CAUSE_STEP;
                    end
                    if (dreq && !in_debug_reg)
                    begin
                        res_data_next.action      = irq_dbg_pkg::ACT_DEBUG;
                        res_data_next.debug_cause = cause;
                        res_data_next.saved_pc    = evt.data.pc;
                        res_data_next.target_pc   = debug_handler_reg;
                        step_armed_next           = 1'b0;
                        in_debug_next             = 1'b1;
                        request_cause_next        = irq_dbg_pkg::CAUSE_HALTREQ;
                        debug_request_next        = 1'b0;
                    end
                    else if (!in_debug_reg &&
                             !(step_armed_reg && !evt.data.step_irq_enable) &&
                             (lines != 32'd0) && evt.data.global_irq_enable)
                    begin
                        res_data_next.action       = irq_dbg_pkg::ACT_IRQ;
                        res_data_next.interrupt_id = line_id;
                        res_data_next.saved_pc     = evt.data.pc;
                        res_data_next.target_pc    = vec_entry;
                    end
                end
            end
            irq_dbg_pkg::MODE_HALT_WIRE:
            begin
                halt_level_next = evt.data.wire_level;
                if (evt.data.wire_level)
                begin
                    debug_request_next        = 1'b1;
                    res_data_next.wfi_release = 1'b1;
                end
            end
            irq_dbg_pkg::MODE_DRET:
            begin
                if (evt.data.step_enable)
                begin
                    step_armed_next   = 1'b1;
                    step_address_next = evt.data.pc;
                end
                in_debug_next = 1'b0;
            end
            default:
            begin
                res_data_next.wfi_release = evt.data.wire_level;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_level_reg    <= 1'b0;
            debug_request_reg <= 1'b0;
            request_cause_reg <= irq_dbg_pkg::CAUSE_HALTREQ;
            step_armed_reg    <= 1'b0;
            step_address_reg  <= 32'd0;
            in_debug_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                halt_level_reg    <= halt_level_next;
                debug_request_reg <= debug_request_next;
                request_cause_reg <= request_cause_next;
                step_armed_reg    <= step_armed_next;
                step_address_reg  <= step_address_next;
                in_debug_reg      <= in_debug_next;
                res_valid_reg     <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_data_reg <= res_data_next;
        end
    end

    // Entering debug mode always comes with a debug entry result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_debug_reg) |-> res_valid_reg && res_data_reg.action == irq_dbg_pkg::ACT_DEBUG)
        else $error("debug mode entered without a debug entry result");

    // Every accepted request leaves a result in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted request produced no result");

    // A result with no action carries no addresses.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.action == irq_dbg_pkg::ACT_NONE |->
        res_data_reg.saved_pc == 32'd0 && res_data_reg.target_pc == 32'd0)
        else $error("idle result carries an address");

    // A debug entry never reports an interrupt line.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.action == irq_dbg_pkg::ACT_DEBUG |->
        res_data_reg.interrupt_id == 5'd0)
        else $error("debug entry reports an interrupt line");

    // Requests are held off only while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !evt.ready |-> res_valid_reg)
        else $error("request stalled with an empty result register");

endmodule

[sim/tb_riscv_irq_debug_entry_arbiter_top.sv]
// ---------------------------------------------------------------------------
// Interrupt and debug entry arbiter testbench
// Feeds boundary checks, halt and wake wire changes and drets through the
// request stream, predicts each decision in a behavioral model of the
// arbiter and compares every result field against it. The configuration is
// rewritten between phases over APB, and both stream sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_riscv_irq_debug_entry_arbiter_top;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [irq_dbg_pkg::CFG_ADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    irq_dbg_stream_if #(.payload_t(irq_dbg_pkg::evt_t)) evt_if ();
    irq_dbg_stream_if #(.payload_t(irq_dbg_pkg::res_t)) res_if ();

    riscv_irq_debug_entry_arbiter_top i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow configuration.
    logic [31:0] cfg_base;
    logic        cfg_vectored;
    logic        cfg_trig_en;
    logic [31:0] cfg_trig_addr;
    logic [31:0] cfg_handler;
    logic [31:0] cfg_wired;

    // Shadow arbiter state.
    logic        halt_lvl;
    logic        dbg_req;
    logic [2:0]  req_cause;
    logic        step_armed;
    logic [31:0] step_addr;
    logic        in_dbg;

    irq_dbg_pkg::evt_t request_q[$];
    irq_dbg_pkg::res_t decision_q[$];
    int unsigned mismatch_count;
    bit          evt_taken;
    bit          quiet;
    bit          drain_hold;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned launched;
    logic [31:0] gen_step_pc;

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [4:0] line_priority(input logic [31:0] lines);
        int n;
        for (n = 31; n >= 16; n--)
        begin
            if (lines[n])
            begin
                return 5'(n);
            end
        end
        if (lines[11])
        begin
            return 5'd11;
        end
        if (lines[3])
        begin
            return 5'd3;
        end
        return 5'd7;
    endfunction

    function automatic irq_dbg_pkg::res_t decide_entry(input irq_dbg_pkg::evt_t e);
        irq_dbg_pkg::res_t r;
        logic        trig;
        logic [31:0] lines;
        logic [4:0]  id;
        logic [31:0] base;
        r = '0;
        case (e.mode)
            irq_dbg_pkg::MODE_BOUNDARY:
            begin
                trig = cfg_trig_en && !in_dbg &&
                       (!dbg_req || req_cause == irq_dbg_pkg::CAUSE_HALTREQ) &&
                       !(step_armed && e.pc != step_addr) && e.pc == cfg_trig_addr;
                if (trig)
                begin
                    dbg_req   = 1'b1;
                    req_cause = irq_dbg_pkg::CAUSE_TRIGGER;
                end
                // A suppressed boundary only looks at the trigger.
                if (e.suppress_async && !trig)
                begin
                    return r;
                end
                if (halt_lvl && !dbg_req && !in_dbg)
                begin
                    dbg_req = 1'b1;
                end
                if (step_armed && !in_dbg && !dbg_req && e.pc != step_addr)
                begin
                    dbg_req   = 1'b1;
                    req_cause = irq_dbg_pkg::CAUSE_STEP;
                end
                if (dbg_req && !in_dbg)
                begin
                    step_armed    = 1'b0;
                    in_dbg        = 1'b1;
                    r.action      = irq_dbg_pkg::ACT_DEBUG;
                    r.debug_cause = req_cause;
                    r.saved_pc    = e.pc;
                    r.target_pc   = cfg_handler;
                    req_cause     = irq_dbg_pkg::CAUSE_HALTREQ;
                    dbg_req       = 1'b0;
                    return r;
                end
                if (in_dbg || (step_armed && !e.step_irq_enable))
                begin
                    return r;
                end
                lines = e.pending_lines & cfg_wired;
                if (lines == '0 || !e.global_irq_enable)
                begin
                    return r;
                end
                id = line_priority(lines);
                base = cfg_base & irq_dbg_pkg::VECTOR_BASE_MASK;
                r.action       = irq_dbg_pkg::ACT_IRQ;
                r.interrupt_id = id;
                r.saved_pc     = e.pc;
                r.target_pc    = cfg_vectored ? base + {25'd0, id, 2'b00} : base;
            end
            irq_dbg_pkg::MODE_HALT_WIRE:
            begin
                halt_lvl = e.wire_level;
                if (e.wire_level)
                begin
                    dbg_req       = 1'b1;
                    r.wfi_release = 1'b1;
                end
            end
            irq_dbg_pkg::MODE_DRET:
            begin
                if (e.step_enable)
                begin
                    step_armed = 1'b1;
                    step_addr  = e.pc;
                end
                in_dbg = 1'b0;
            end
            default:
            begin
                r.wfi_release = e.wire_level;
            end
        endcase
        return r;
    endfunction

    task automatic check_result(input irq_dbg_pkg::res_t got, input irq_dbg_pkg::res_t want);
        if (got.action !== want.action)
        begin
            report("action", 32'(got.action), 32'(want.action));
        end
        if (got.debug_cause !== want.debug_cause)
        begin
            report("debug_cause", 32'(got.debug_cause), 32'(want.debug_cause));
        end
        if (got.interrupt_id !== want.interrupt_id)
        begin
            report("interrupt_id", 32'(got.interrupt_id), 32'(want.interrupt_id));
        end
        if (got.saved_pc !== want.saved_pc)
        begin
            report("saved_pc", got.saved_pc, want.saved_pc);
        end
        if (got.target_pc !== want.target_pc)
        begin
            report("target_pc", got.target_pc, want.target_pc);
        end
        if (got.wfi_release !== want.wfi_release)
        begin
            report("wfi_release", 32'(got.wfi_release), 32'(want.wfi_release));
        end
    endtask

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Stream monitor: predicts on each accepted request, checks each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            evt_taken = evt_if.valid && evt_if.ready;
            if (evt_taken)
            begin
                decision_q.push_back(decide_entry(evt_if.data));
            end
            if (res_if.valid && res_if.ready)
            begin
                if (decision_q.size() == 0)
                begin
                    report("unexpected result, saved_pc", res_if.data.saved_pc, 32'd0);
                end
                else
                begin
                    check_result(res_if.data, decision_q.pop_front());
                end
            end
        end
    end

    // Request driver.
    always @(negedge clk)
    begin
        if (rst_n && (!evt_if.valid || evt_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                evt_if.valid <= 1'b0;
            end
            else if (drain_hold && decision_q.size() != 0)
            begin
                evt_if.valid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                drain_hold = ($urandom_range(0, 49) == 0) || (launched == 100);
                launched++;
                evt_if.valid <= 1'b1;
                evt_if.data  <= request_q.pop_front();
                send_gap = idle_len();
            end
            else
            begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            irq_dbg_pkg::REG_VECTOR_BASE:   cfg_base      = val;
            irq_dbg_pkg::REG_VECTORED:      cfg_vectored  = val[0];
            irq_dbg_pkg::REG_TRIG_ENABLE:   cfg_trig_en   = val[0];
            irq_dbg_pkg::REG_TRIG_ADDRESS:  cfg_trig_addr = val;
            irq_dbg_pkg::REG_DEBUG_HANDLER: cfg_handler   = val;
            irq_dbg_pkg::REG_WIRED_MASK:    cfg_wired     = val;
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [31:0] base, input logic vec, input logic ten,
                           input logic [31:0] taddr, input logic [31:0] handler,
                           input logic [31:0] wired);
        cfg_write(irq_dbg_pkg::REG_VECTOR_BASE, base);
        cfg_write(irq_dbg_pkg::REG_VECTORED, {31'd0, vec});
        cfg_write(irq_dbg_pkg::REG_TRIG_ENABLE, {31'd0, ten});
        cfg_write(irq_dbg_pkg::REG_TRIG_ADDRESS, taddr);
        cfg_write(irq_dbg_pkg::REG_DEBUG_HANDLER, handler);
        cfg_write(irq_dbg_pkg::REG_WIRED_MASK, wired);
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || evt_if.valid || decision_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    function automatic irq_dbg_pkg::evt_t mk(input irq_dbg_pkg::mode_t m,
                                             input logic [31:0] pc, input logic [31:0] pend,
                                             input logic gie, input logic sup,
                                             input logic lvl, input logic step,
                                             input logic stirq);
        irq_dbg_pkg::evt_t e;
        e.mode              = m;
        e.pc                = pc;
        e.pending_lines     = pend;
        e.global_irq_enable = gie;
        e.suppress_async    = sup;
        e.wire_level        = lvl;
        e.step_enable       = step;
        e.step_irq_enable   = stirq;
        return e;
    endfunction

    function automatic irq_dbg_pkg::evt_t rand_req(input irq_dbg_pkg::mode_t m);
        irq_dbg_pkg::evt_t e;
        int unsigned r;
        e = mk(m, $urandom, $urandom, $urandom_range(0, 4) != 0, $urandom_range(0, 9) == 0,
               1'($urandom_range(0, 1)), $urandom_range(0, 4) < 3,
               1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            e.pc = cfg_trig_addr;
        end
        else if (r < 40)
        begin
            e.pc = gen_step_pc;
        end
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            e.pending_lines = 32'd1 << $urandom_range(0, 31);
        end
        else if (r < 35)
        begin
            e.pending_lines = '0;
        end
        if (m == irq_dbg_pkg::MODE_DRET && e.step_enable)
        begin
            gen_step_pc = e.pc;
        end
        return e;
    endfunction

    // Halt, stay in debug, resume with a step, and let the step close.
    task automatic add_step_sequence();
        irq_dbg_pkg::evt_t e;
        e = rand_req(irq_dbg_pkg::MODE_HALT_WIRE);
        e.wire_level = 1'b1;
        request_q.push_back(e);
        e = rand_req(irq_dbg_pkg::MODE_BOUNDARY);
        e.suppress_async = 1'b0;
        request_q.push_back(e);
        request_q.push_back(rand_req(irq_dbg_pkg::MODE_BOUNDARY));
        e = rand_req(irq_dbg_pkg::MODE_HALT_WIRE);
        e.wire_level = 1'b0;
        request_q.push_back(e);
        e = rand_req(irq_dbg_pkg::MODE_DRET);
        e.step_enable = 1'b1;
        gen_step_pc = e.pc;
        request_q.push_back(e);
        e = rand_req(irq_dbg_pkg::MODE_BOUNDARY);
        e.pc = gen_step_pc;
        request_q.push_back(e);
        e = rand_req(irq_dbg_pkg::MODE_BOUNDARY);
        e.suppress_async = 1'b0;
        request_q.push_back(e);
        e = rand_req(irq_dbg_pkg::MODE_DRET);
        e.step_enable = 1'b0;
        request_q.push_back(e);
    endtask

    task automatic add_random(input int unsigned count);
        int unsigned added;
        int unsigned r;
        added = 0;
        while (added < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                add_step_sequence();
                added += 8;
            end
            else
            begin
                if (r < 60)
                begin
                    request_q.push_back(rand_req(irq_dbg_pkg::MODE_BOUNDARY));
                end
                else if (r < 72)
                begin
                    request_q.push_back(rand_req(irq_dbg_pkg::MODE_HALT_WIRE));
                end
                else if (r < 87)
                begin
                    request_q.push_back(rand_req(irq_dbg_pkg::MODE_DRET));
                end
                else
                begin
                    request_q.push_back(rand_req(irq_dbg_pkg::MODE_WAKE_WIRE));
                end
                added++;
            end
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        evt_if.valid  = 1'b0;
        evt_if.data   = '0;
        res_if.ready  = 1'b0;
        cfg_base      = '0;
        cfg_vectored  = 1'b0;
        cfg_trig_en   = 1'b0;
        cfg_trig_addr = '0;
        cfg_handler   = '0;
        cfg_wired     = irq_dbg_pkg::WIRED_MASK_RESET;
        halt_lvl      = 1'b0;
        dbg_req       = 1'b0;
        req_cause     = irq_dbg_pkg::CAUSE_HALTREQ;
        step_armed    = 1'b0;
        step_addr     = '0;
        in_dbg        = 1'b0;
        mismatch_count = 0;
        evt_taken     = 1'b0;
        quiet         = 1'b0;
        drain_hold    = 1'b0;
        send_gap      = 0;
        stall_left    = 0;
        launched      = 0;
        gen_step_pc   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, wired mask left at its reset value.
        cfg_write(irq_dbg_pkg::REG_VECTOR_BASE, 32'hFFFF_FFFF);
        cfg_write(irq_dbg_pkg::REG_VECTORED, 32'd1);
        cfg_write(irq_dbg_pkg::REG_TRIG_ENABLE, 32'd1);
        cfg_write(irq_dbg_pkg::REG_TRIG_ADDRESS, 32'h0000_1000);
        cfg_write(irq_dbg_pkg::REG_DEBUG_HANDLER, 32'h0000_0800);
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h0, 32'h0,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'hFFFF_FFFF, 32'h8000_0000,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h10, 32'h0001_0000,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h14, 32'h0000_0808,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h18, 32'h0000_0008,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h1C, 32'h0000_0080,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h20, 32'hFFFF_FFFF,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h24, 32'h0000_0001,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_WAKE_WIRE, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_WAKE_WIRE, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // A latched halt request survives the wire dropping again.
        request_q.push_back(mk(irq_dbg_pkg::MODE_HALT_WIRE, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_HALT_WIRE, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h40, 32'hFFFF_FFFF,
                               1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h44, 32'hFFFF_FFFF,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h48, 32'hFFFF_FFFF,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        request_q.push_back(mk(irq_dbg_pkg::MODE_DRET, 32'h2000, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h2000, 32'h0010_0000,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h2000, 32'h0010_0000,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h2004, 32'h0010_0000,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        request_q.push_back(mk(irq_dbg_pkg::MODE_DRET, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_DRET, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // The trigger fires even on a suppressed boundary and at the step address.
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h1000, 32'hFFFF_FFFF,
                               1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_DRET, 32'h1000, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        request_q.push_back(mk(irq_dbg_pkg::MODE_BOUNDARY, 32'h1000, 32'hFFFF_FFFF,
                               1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        request_q.push_back(mk(irq_dbg_pkg::MODE_DRET, 32'h0, 32'h0,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        wait_idle();

        for (int phase = 1; phase <= 5; phase++)
        begin
            case (phase)
                1: set_cfg($urandom, 1'b1, 1'b1, $urandom, $urandom,
                           irq_dbg_pkg::WIRED_MASK_RESET);
                2: set_cfg(32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF);
                3: set_cfg(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
                default: set_cfg($urandom, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 3) != 0,
                                 $urandom, $urandom, $urandom);
            endcase
            quiet = (phase == 2);
            add_random(200);
            wait_idle();
        end

        if (decision_q.size() != 0)
        begin
            report("results missing", 32'(decision_q.size()), 32'd0);
        end
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
